// File: rtl/relop_id_number_lexer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lexer
// Checks are compiled in simulation and compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef RELOP_ID_NUMBER_LEXER_ASSERT_SVH
`define RELOP_ID_NUMBER_LEXER_ASSERT_SVH

`ifndef SYNTHESIS
// Property checked on every rising clock edge outside reset.
`define RILX_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Condition that must never be seen outside reset.
`define RILX_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define RILX_ASSERT(label, prop, msg)
`define RILX_ASSERT_NEVER(label, cond, msg)
`endif

`endif

// File: rtl/rilx_pkg.sv
// ----------------------------------------------------------------------------
// rilx_pkg
// Scan states, token kinds and character codes of the lexer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rilx_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LT,
		ST_GT,
		ST_IDENT,
		ST_INT,
		ST_FRAC,
		ST_WS,
		ST_ERR
	} scan_state_t;

	typedef enum logic [3:0] {
		KIND_LT,
		KIND_LE,
		KIND_NE,
		KIND_GT,
		KIND_GE,
		KIND_EQ,
		KIND_ID,
		KIND_NUM,
		KIND_WS,
		KIND_ERR
	} token_kind_t;

	// One byte fills at most two of the three slots: the token it ends, and
	// either an equals or error token it starts or a flush at the end of the stream.
	localparam int unsigned NUM_SLOTS = 3;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;

endpackage

// File: rtl/relop_id_number_lexer.sv
// ----------------------------------------------------------------------------
// relop_id_number_lexer
// Byte-stream lexer for relational operators, identifiers, numbers and
// whitespace. Text enters on s_axis one byte per word; tlast marks the last
// byte of a stream, which flushes the open token and restarts offsets at 0.
// Tokens leave on m_axis as kind, start offset and length. tlast marks the
// last token caused by one input byte; tuser bit 4 marks the final token of
// a stream. An unknown byte gives an error token, and later bytes are
// ignored until the end of the stream.
// A byte is registered on acceptance and scanned once the result register
// is free; its tokens are registered there and driven on m_axis from it.
// One byte is taken every cycle while each byte yields at most one token and
// m_axis does not stall; a byte that yields two tokens holds the input until
// both have left, since the result register drains one token per cycle.
// When m_axis stalls, the result register holds its tokens, the scanned byte
// waits in the input register, and s_axis_tready falls once both are full.
// Reset clears the scanner to idle, all offsets to zero and disables
// whitespace tokens. cfg_wr_en writes emit_whitespace; write it while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "relop_id_number_lexer_assert.svh"

module relop_id_number_lexer import rilx_pkg::*; #(
	parameter int unsigned OFFSET_BITS = 32,
	parameter int unsigned LENGTH_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,

	// Configuration: emit_whitespace.
	input  logic cfg_wr_en,
	input  logic cfg_wr_data,

	// Text input. tdata: in_byte [7:0]. tlast: stream_end.
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,
	input  logic       s_axis_tlast,

	// Token output. tdata: token_offset, then token_length, zero padded.
	// tuser: token_kind [3:0], stream_final [4]. tlast: run_last.
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	output logic [((OFFSET_BITS+LENGTH_BITS+7)/8)*8-1:0] m_axis_tdata,
	output logic [4:0]                              m_axis_tuser,
	output logic                                    m_axis_tlast
);

	// Configuration register.
	logic emit_ws_q;

	// Input register: one byte waiting to be scanned.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Scanner state carried from byte to byte.
	scan_state_t            scan_q;
	logic [OFFSET_BITS-1:0] start_q;
	logic [LENGTH_BITS-1:0] len_q;
	logic [OFFSET_BITS-1:0] pos_q;

	// Result register: the tokens of one byte, drained lowest slot first.
	logic [NUM_SLOTS-1:0]   res_mask_q;
	token_kind_t            res_kind_q   [NUM_SLOTS];
	logic [OFFSET_BITS-1:0] res_offset_q [NUM_SLOTS];
	logic [LENGTH_BITS-1:0] res_length_q [NUM_SLOTS];
	logic                   res_end_q;

	// Scanner outputs.
	scan_state_t            next_state;
	logic [OFFSET_BITS-1:0] next_start;
	logic [LENGTH_BITS-1:0] next_length;
	logic [OFFSET_BITS-1:0] next_position;
	logic [NUM_SLOTS-1:0]   step_valid;
	token_kind_t            step_kind   [NUM_SLOTS];
	logic [OFFSET_BITS-1:0] step_offset [NUM_SLOTS];
	logic [LENGTH_BITS-1:0] step_length [NUM_SLOTS];

	// Handshake control.
	logic [1:0]           sel;
	logic [NUM_SLOTS-1:0] mask_after_pop;
	logic                 pop;
	logic                 out_done;
	logic                 advance;
	logic                 accept;

	rilx_step #(
		.OFFSET_BITS(OFFSET_BITS),
		.LENGTH_BITS(LENGTH_BITS)
	) u_step (
		.scan_state     (scan_q),
		.start_offset   (start_q),
		.run_length     (len_q),
		.byte_position  (pos_q),
		.in_byte        (byte_s1),
		.stream_end     (last_s1),
		.emit_whitespace(emit_ws_q),
		.next_state     (next_state),
		.next_start     (next_start),
		.next_length    (next_length),
		.next_position  (next_position),
		.res_valid      (step_valid),
		.res_kind       (step_kind),
		.res_offset     (step_offset),
		.res_length     (step_length)
	);

	// The lowest pending slot is the one on the bus.
	always_comb begin
		if (res_mask_q[0]) begin
			sel = 2'd0;
		end else if (res_mask_q[1]) begin
			sel = 2'd1;
		end else begin
			sel = 2'd2;
		end
	end

	assign mask_after_pop = res_mask_q & ~(NUM_SLOTS'(1) << sel);
	assign m_axis_tvalid  = |res_mask_q;
	assign pop            = m_axis_tvalid && m_axis_tready;
	// The result register frees up when empty or when its last token leaves.
	assign out_done       = !m_axis_tvalid || (pop && (mask_after_pop == '0));
	assign advance        = valid_s1 && out_done;
	assign s_axis_tready  = !valid_s1 || advance;
	assign accept         = s_axis_tvalid && s_axis_tready;

	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[OFFSET_BITS-1:0] = res_offset_q[sel];
		m_axis_tdata[OFFSET_BITS +: LENGTH_BITS] = res_length_q[sel];
	end
	assign m_axis_tlast = (mask_after_pop == '0);
	assign m_axis_tuser = {res_end_q && (mask_after_pop == '0), res_kind_q[sel]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_ws_q <= 1'b0;
		end else if (cfg_wr_en) begin
			emit_ws_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= ST_IDLE;
			start_q <= '0;
			len_q   <= '0;
			pos_q   <= '0;
		end else if (advance) begin
			scan_q  <= next_state;
			start_q <= next_start;
			len_q   <= next_length;
			pos_q   <= next_position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_mask_q <= '0;
		end else if (advance) begin
			res_mask_q <= step_valid;
		end else if (pop) begin
			res_mask_q <= mask_after_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_kind_q   <= step_kind;
			res_offset_q <= step_offset;
			res_length_q <= step_length;
			res_end_q    <= last_s1;
		end
	end

	// An error stays until the end of its stream.
	`RILX_ASSERT(a_error_sticks, (scan_q == ST_ERR) && !(advance && last_s1) |=> (scan_q == ST_ERR), "error state left before stream end")
	// The end of a stream restarts the scanner from idle at offset zero.
	`RILX_ASSERT(a_stream_restart, advance && last_s1 |=> (scan_q == ST_IDLE) && (pos_q == '0) && (len_q == '0), "scanner not reset at stream end")
	// An error token always covers exactly the bad byte.
	`RILX_ASSERT(a_error_length, m_axis_tvalid && (res_kind_q[sel] == KIND_ERR) |-> (res_length_q[sel] == LENGTH_BITS'(1)), "error token length not one")
	// A new byte is never scanned over tokens that are still waiting.
	`RILX_ASSERT_NEVER(a_no_overwrite, advance && m_axis_tvalid && !(pop && m_axis_tlast), "result register overwritten")

endmodule

// File: rtl/rilx_step.sv
// ----------------------------------------------------------------------------
// rilx_step
// One transition of the scanning automaton: next state and up to two tokens.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rilx_step import rilx_pkg::*; #(
	parameter int unsigned OFFSET_BITS = 32,
	parameter int unsigned LENGTH_BITS = 16
) (
	input  scan_state_t            scan_state,
	input  logic [OFFSET_BITS-1:0] start_offset,
	input  logic [LENGTH_BITS-1:0] run_length,
	input  logic [OFFSET_BITS-1:0] byte_position,
	input  logic [7:0]             in_byte,
	input  logic                   stream_end,
	input  logic                   emit_whitespace,
	output scan_state_t            next_state,
	output logic [OFFSET_BITS-1:0] next_start,
	output logic [LENGTH_BITS-1:0] next_length,
	output logic [OFFSET_BITS-1:0] next_position,
	output logic [NUM_SLOTS-1:0]   res_valid,
	output token_kind_t            res_kind   [NUM_SLOTS],
	output logic [OFFSET_BITS-1:0] res_offset [NUM_SLOTS],
	output logic [LENGTH_BITS-1:0] res_length [NUM_SLOTS]
);

	localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);
	localparam logic [LENGTH_BITS-1:0] LEN_TWO = LENGTH_BITS'(2);
	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

	logic is_letter;
	logic is_digit;
	logic is_space;
	logic rescan;
	logic [LENGTH_BITS-1:0] grown;
	scan_state_t            mid_state;
	logic [OFFSET_BITS-1:0] mid_start;
	logic [LENGTH_BITS-1:0] mid_len;

	assign is_letter = ((in_byte >= CH_UA) && (in_byte <= CH_UZ)) ||
	                   ((in_byte >= CH_LA) && (in_byte <= CH_LZ));
	assign is_digit  = (in_byte >= CH_0) && (in_byte <= CH_9);
	assign is_space  = (in_byte == CH_TAB) || (in_byte == CH_SPACE) ||
	                   (in_byte == CH_NL) || (in_byte == CH_SEMI);
	assign grown     = (run_length == LEN_MAX) ? run_length : run_length + LEN_ONE;
	assign next_position = stream_end ? '0 : byte_position + OFFSET_BITS'(1);

	always_comb begin
		mid_state = scan_state;
		mid_start = start_offset;
		mid_len   = run_length;
		rescan    = 1'b0;
		res_valid = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			res_kind[i]   = KIND_ERR;
			res_offset[i] = '0;
			res_length[i] = '0;
		end

		// Slot 0: the pending token, when this byte ends it.
		case (scan_state)
			ST_LT: begin
				res_valid[0]  = 1'b1;
				res_offset[0] = start_offset;
				if (in_byte == CH_EQ) begin
					res_kind[0]   = KIND_LE;
					res_length[0] = LEN_TWO;
					mid_state     = ST_IDLE;
				end else if (in_byte == CH_GT) begin
					res_kind[0]   = KIND_NE;
					res_length[0] = LEN_TWO;
					mid_state     = ST_IDLE;
				end else begin
					res_kind[0]   = KIND_LT;
					res_length[0] = LEN_ONE;
					rescan        = 1'b1;
				end
			end
			ST_GT: begin
				res_valid[0]  = 1'b1;
				res_offset[0] = start_offset;
				if (in_byte == CH_EQ) begin
					res_kind[0]   = KIND_GE;
					res_length[0] = LEN_TWO;
					mid_state     = ST_IDLE;
				end else begin
					res_kind[0]   = KIND_GT;
					res_length[0] = LEN_ONE;
					rescan        = 1'b1;
				end
			end
			ST_IDENT: begin
				if (is_letter || is_digit) begin
					mid_len = grown;
				end else begin
					res_valid[0]  = 1'b1;
					res_kind[0]   = KIND_ID;
					res_offset[0] = start_offset;
					res_length[0] = run_length;
					rescan        = 1'b1;
				end
			end
			ST_INT, ST_FRAC: begin
				if (is_digit) begin
					mid_len = grown;
				end else if ((scan_state == ST_INT) && (in_byte == CH_DOT)) begin
					mid_len   = grown;
					mid_state = ST_FRAC;
				end else begin
					res_valid[0]  = 1'b1;
					res_kind[0]   = KIND_NUM;
					res_offset[0] = start_offset;
					res_length[0] = run_length;
					rescan        = 1'b1;
				end
			end
			ST_WS: begin
				if (is_space) begin
					mid_len = grown;
				end else begin
					res_valid[0]  = emit_whitespace;
					res_kind[0]   = KIND_WS;
					res_offset[0] = start_offset;
					res_length[0] = run_length;
					rescan        = 1'b1;
				end
			end
			ST_ERR: begin
				mid_state = ST_ERR;
			end
			default: begin
				rescan = 1'b1;
			end
		endcase

		// Slot 1: the byte is scanned again from idle, after a token ended or when idle.
		if (rescan) begin
			mid_state = ST_IDLE;
			if (in_byte == CH_EQ) begin
				res_valid[1]  = 1'b1;
				res_kind[1]   = KIND_EQ;
				res_offset[1] = byte_position;
				res_length[1] = LEN_ONE;
			end else if (in_byte == CH_LT || in_byte == CH_GT || is_letter ||
			             is_digit || is_space) begin
				mid_start = byte_position;
				mid_len   = LEN_ONE;
				if (in_byte == CH_LT) begin
					mid_state = ST_LT;
				end else if (in_byte == CH_GT) begin
					mid_state = ST_GT;
				end else if (is_letter) begin
					mid_state = ST_IDENT;
				end else if (is_digit) begin
					mid_state = ST_INT;
				end else begin
					mid_state = ST_WS;
				end
			end else begin
				res_valid[1]  = 1'b1;
				res_kind[1]   = KIND_ERR;
				res_offset[1] = byte_position;
				res_length[1] = LEN_ONE;
				mid_state     = ST_ERR;
			end
		end

		// Slot 2: end of stream flushes whatever token is still open.
		res_offset[2] = mid_start;
		res_length[2] = mid_len;
		if (stream_end) begin
			case (mid_state)
				ST_LT: begin
					res_valid[2]  = 1'b1;
					res_kind[2]   = KIND_LT;
					res_length[2] = LEN_ONE;
				end
				ST_GT: begin
					res_valid[2]  = 1'b1;
					res_kind[2]   = KIND_GT;
					res_length[2] = LEN_ONE;
				end
				ST_IDENT: begin
					res_valid[2] = 1'b1;
					res_kind[2]  = KIND_ID;
				end
				ST_INT, ST_FRAC: begin
					res_valid[2] = 1'b1;
					res_kind[2]  = KIND_NUM;
				end
				ST_WS: begin
					res_valid[2] = emit_whitespace;
					res_kind[2]  = KIND_WS;
				end
				default: begin
					res_valid[2] = 1'b0;
				end
			endcase
			next_state  = ST_IDLE;
			next_start  = '0;
			next_length = '0;
		end else begin
			next_state  = mid_state;
			next_start  = mid_start;
			next_length = mid_len;
		end
	end

endmodule
